// ===== design/tcbpa_pkg.sv =====
package tcbpa_pkg;

  localparam int SIZE_W     = 16;
  localparam int IDX_W      = 6;
  localparam int MAX_BLOCKS = 64;
  localparam int CFG_IDX_W  = 2;

  typedef logic [SIZE_W-1:0]     size_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [MAX_BLOCKS-1:0] wide_mask_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CLS_SMALL  = 2'd0,
    CLS_MEDIUM = 2'd1,
    CLS_LARGE  = 2'd2,
    CLS_NONE   = 2'd3
  } pool_cls_t;

  localparam logic [CFG_IDX_W-1:0] REG_SMALL_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MEDIUM_LIMIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LARGE_LIMIT  = 2'd2;

  typedef struct packed {
    logic found;
    idx_t idx;
  } ffz_t;

  // lowest clear bit of a 64-bit mask; unused upper bits are padded with ones
  function automatic ffz_t find_first_zero(input wide_mask_t m);
    ffz_t r;
    r.found = 1'b0;
    r.idx   = '0;
    for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
      if (!m[i]) begin
        r.found = 1'b1;
        r.idx   = IDX_W'(i);
      end
    end
    return r;
  endfunction

endpackage

// ===== design/three_class_block_pool_allocator.sv =====
// Channel   | Signals                                         | Handshake
// ----------+-------------------------------------------------+-------------------------------
// request   | opcode, req_size, free_class, free_index        | start & !busy
// result    | granted, pool_class, block_index                | done strobe, one cycle
// config    | cfg_index, cfg_data                             | cfg_write
//
// One request per cycle. The request is registered on acceptance; class select,
// find-first-free over the chosen pool mask and the mask update happen in the next
// cycle, and done is registered with the mask update. busy stays low: the mask update of
// one transaction lands at the same edge the next one enters the input register.
// Synchronous reset clears all pool masks and restores the default limits.
// The receiver cannot stall; every result is shown for exactly one cycle.
module three_class_block_pool_allocator
  import tcbpa_pkg::*;
#(
  parameter int SMALL_BLOCKS  = 16,
  parameter int MEDIUM_BLOCKS = 16,
  parameter int LARGE_BLOCKS  = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic                 opcode,
  input  logic [SIZE_W-1:0]    req_size,
  input  logic [1:0]           free_class,
  input  logic [IDX_W-1:0]     free_index,
  output logic                 done,
  output logic                 granted,
  output logic [1:0]           pool_class,
  output logic [IDX_W-1:0]     block_index,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SIZE_W-1:0]    cfg_data
);

  size_t small_limit, medium_limit, large_limit;

  logic [SMALL_BLOCKS-1:0]  small_used,  small_used_next;
  logic [MEDIUM_BLOCKS-1:0] medium_used, medium_used_next;
  logic [LARGE_BLOCKS-1:0]  large_used,  large_used_next;

  // input register
  logic      in_valid;
  logic      in_op;
  size_t     in_size;
  logic [1:0] in_fcls;
  idx_t      in_fidx;

  logic       granted_next;
  logic [1:0] pool_class_next;
  idx_t       block_index_next;

  pool_cls_t  alloc_cls;
  wide_mask_t sel_mask;
  ffz_t       ffz;
  wide_mask_t onehot;
  logic       free_ok;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      small_limit  <= SIZE_W'(32);
      medium_limit <= SIZE_W'(128);
      large_limit  <= SIZE_W'(512);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SMALL_LIMIT:  small_limit  <= cfg_data;
        REG_MEDIUM_LIMIT: medium_limit <= cfg_data;
        REG_LARGE_LIMIT:  large_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_op   <= opcode;
      in_size <= req_size;
      in_fcls <= free_class;
      in_fidx <= free_index;
    end
  end

  always_comb begin
    if (in_size <= small_limit) begin
      alloc_cls = CLS_SMALL;
    end else if (in_size <= medium_limit) begin
      alloc_cls = CLS_MEDIUM;
    end else if (in_size <= large_limit) begin
      alloc_cls = CLS_LARGE;
    end else begin
      alloc_cls = CLS_NONE;
    end
  end

  // bits beyond the pool size read as used
  always_comb begin
    case (alloc_cls)
      CLS_SMALL:  sel_mask = (~wide_mask_t'(0) << SMALL_BLOCKS)  | wide_mask_t'(small_used);
      CLS_MEDIUM: sel_mask = (~wide_mask_t'(0) << MEDIUM_BLOCKS) | wide_mask_t'(medium_used);
      CLS_LARGE:  sel_mask = (~wide_mask_t'(0) << LARGE_BLOCKS)  | wide_mask_t'(large_used);
      default:    sel_mask = ~wide_mask_t'(0);
    endcase
  end

  assign ffz = find_first_zero(sel_mask);

  always_comb begin
    case (in_fcls)
      CLS_SMALL:  free_ok = {1'b0, in_fidx} < (IDX_W + 1)'(SMALL_BLOCKS);
      CLS_MEDIUM: free_ok = {1'b0, in_fidx} < (IDX_W + 1)'(MEDIUM_BLOCKS);
      CLS_LARGE:  free_ok = {1'b0, in_fidx} < (IDX_W + 1)'(LARGE_BLOCKS);
      default:    free_ok = 1'b0;
    endcase
  end

  always_comb begin
    small_used_next  = small_used;
    medium_used_next = medium_used;
    large_used_next  = large_used;
    granted_next     = 1'b0;
    pool_class_next  = CLS_SMALL;
    block_index_next = '0;
    onehot           = '0;
    if (in_valid) begin
      if (in_op == OP_ALLOC) begin
        onehot = wide_mask_t'(1) << ffz.idx;
        if (ffz.found) begin
          granted_next     = 1'b1;
          pool_class_next  = alloc_cls;
          block_index_next = ffz.idx;
          case (alloc_cls)
            CLS_SMALL:  small_used_next  = small_used  | onehot[SMALL_BLOCKS-1:0];
            CLS_MEDIUM: medium_used_next = medium_used | onehot[MEDIUM_BLOCKS-1:0];
            CLS_LARGE:  large_used_next  = large_used  | onehot[LARGE_BLOCKS-1:0];
            default: ;
          endcase
        end
      end else begin
        onehot = wide_mask_t'(1) << in_fidx;
        if (free_ok) begin
          granted_next     = 1'b1;
          pool_class_next  = in_fcls;
          block_index_next = in_fidx;
          case (in_fcls)
            CLS_SMALL:  small_used_next  = small_used  & ~onehot[SMALL_BLOCKS-1:0];
            CLS_MEDIUM: medium_used_next = medium_used & ~onehot[MEDIUM_BLOCKS-1:0];
            CLS_LARGE:  large_used_next  = large_used  & ~onehot[LARGE_BLOCKS-1:0];
            default: ;
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      small_used  <= '0;
      medium_used <= '0;
      large_used  <= '0;
      done        <= 1'b0;
    end else begin
      small_used  <= small_used_next;
      medium_used <= medium_used_next;
      large_used  <= large_used_next;
      done        <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    granted     <= granted_next;
    pool_class  <= pool_class_next;
    block_index <= block_index_next;
  end

  a_done_follows_start: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(rst, 2) |-> done == $past(start, 2))
    else $error("result strobe does not follow accepted transaction");

  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    done && !granted |-> pool_class == CLS_SMALL && block_index == '0)
    else $error("refused result carries nonzero handle");

  a_index_in_pool: assert property (@(posedge clk) disable iff (rst)
    done && granted |->
      (pool_class == CLS_SMALL  && {1'b0, block_index} < (IDX_W + 1)'(SMALL_BLOCKS)) ||
      (pool_class == CLS_MEDIUM && {1'b0, block_index} < (IDX_W + 1)'(MEDIUM_BLOCKS)) ||
      (pool_class == CLS_LARGE  && {1'b0, block_index} < (IDX_W + 1)'(LARGE_BLOCKS)))
    else $error("granted handle outside its pool");

  a_one_bit_per_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |->
      $countones(small_used) + $countones(medium_used) + $countones(large_used) <=
      $countones($past(small_used)) + $countones($past(medium_used)) +
      $countones($past(large_used)) + 1)
    else $error("more than one block marked used in one cycle");

  a_masks_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(in_valid) |->
      $stable(small_used) && $stable(medium_used) && $stable(large_used))
    else $error("pool mask changed without a transaction");

endmodule
